@@ rtl/rwl_pkg.sv @@
// ----------------------------------------------------------------------------
// rwl_pkg
// Shared types and constants of the readers-writer lock bank: request codes,
// response codes, lock modes and the layout of the lock table and link table.
// ----------------------------------------------------------------------------
package rwl_pkg;

   // Sizes of the lock bank and the task space.
   localparam int LOCK_W    = 3;
   localparam int NUM_LOCKS = 1 << LOCK_W;
   localparam int TASK_W    = 4;
   localparam int NUM_TASKS = 1 << TASK_W;
   localparam int QIDX_W    = TASK_W + 1;
   localparam int CNT_W     = 5;
   localparam int MAX_WAKE  = 16;
   localparam int WAKE_W    = $clog2(MAX_WAKE);

   // Queue pointer value that marks an empty queue.
   localparam logic [QIDX_W-1:0] EMPTY_Q = QIDX_W'(NUM_TASKS);
   localparam logic [CNT_W-1:0]  CNT_MAX = '1;

   // Request actions.
   localparam logic [1:0] ACT_READ    = 2'd0;
   localparam logic [1:0] ACT_WRITE   = 2'd1;
   localparam logic [1:0] ACT_RELEASE = 2'd2;
   localparam logic [1:0] ACT_REINIT  = 2'd3;

   // Response status codes.
   localparam logic [2:0] ST_GRANTED    = 3'd0;
   localparam logic [2:0] ST_QUEUED     = 3'd1;
   localparam logic [2:0] ST_REFUSED    = 3'd2;
   localparam logic [2:0] ST_STILL_HELD = 3'd3;
   localparam logic [2:0] ST_NOW_FREE   = 3'd4;
   localparam logic [2:0] ST_HANDED     = 3'd5;
   localparam logic [2:0] ST_BAD_REL    = 3'd6;

   // Lock modes.
   localparam logic [1:0] MODE_FREE  = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_WRITE = 2'd2;
   localparam logic [1:0] MODE_PEND  = 2'd3;

   // One entry of the lock table. The head waiter's access type is kept here
   // so that a wake step needs only one read of the link table.
   typedef struct packed {
      logic [1:0]        mode;
      logic [CNT_W-1:0]  count;
      logic [QIDX_W-1:0] head;
      logic [QIDX_W-1:0] tail;
      logic              head_ww;
   } lock_entry_type;

   // One entry of the link table: the waiter behind this task and its type.
   typedef struct packed {
      logic [TASK_W-1:0] id;
      logic              ww;
   } link_entry_type;

   localparam lock_entry_type LOCK_RESET = '{
      mode:    MODE_FREE,
      count:   '0,
      head:    EMPTY_Q,
      tail:    EMPTY_Q,
      head_ww: 1'b0
   };

endpackage

@@ rtl/rwl_lock_tbl.sv @@
// ----------------------------------------------------------------------------
// rwl_lock_tbl
// Lock table: one synchronous memory entry per lock with a registered read.
// A valid bit per entry makes a never-written entry read as a free lock.
// ----------------------------------------------------------------------------
module rwl_lock_tbl
   import rwl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  logic [LOCK_W-1:0]     rd_addr,
   output lock_entry_type        rd_data,
   input  logic                  wr_en,
   input  logic [LOCK_W-1:0]     wr_addr,
   input  lock_entry_type        wr_data
);

   lock_entry_type         mem [NUM_LOCKS];
   lock_entry_type         rd_q_ff;
   logic                   rd_valid_ff;
   logic [NUM_LOCKS-1:0]   valid_ff;

   // Memory array: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= mem[rd_addr];
      end
   end

   // Valid bits, cleared by reset, and the valid bit of the last read.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_q_ff : LOCK_RESET;

endmodule

@@ rtl/rw_lock_with_fifo_waiters_top.sv @@
// Responses are registered. A request is taken only while busy is low; the block
// reads the lock table, updates the entry and registers the response. A release
// that wakes waiters then walks the queue through the link table, one woken task
// per cycle, paced by the link table read.
// Reset clears all locks to free with empty queues and no task waiting.
// Responses are strobed for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
// rw_lock_with_fifo_waiters_top
// Bank of readers-writer locks with writer preference and FIFO wait queues
// linked through a per-task link table.
// ----------------------------------------------------------------------------
module rw_lock_with_fifo_waiters_top
   import rwl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_action,
   input  logic [LOCK_W-1:0] req_lock_index,
   input  logic [TASK_W-1:0] req_task_id,
   output logic              rsp_valid,
   output logic [2:0]        rsp_status,
   output logic              rsp_woken_valid,
   output logic [TASK_W-1:0] rsp_woken_task,
   output logic              rsp_woken_for_write,
   output logic              rsp_last
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_LOOKUP = 2'd1;
   localparam logic [1:0] S_WAKE   = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [1:0]          act_ff;
   logic [LOCK_W-1:0]   lk_ff;
   logic [TASK_W-1:0]   tid_ff;
   lock_entry_type      wk_ff, wk_in;
   logic [WAKE_W-1:0]   wake_cnt_ff, wake_cnt_in;
   logic [NUM_TASKS-1:0] waiting_ff, waiting_in;
   logic [LOCK_W-1:0]   wait_lock_ff [NUM_TASKS];
   logic                wl_wr_en;

   link_entry_type      link_mem [NUM_TASKS];
   link_entry_type      link_rd_ff;
   logic                link_wr_en;
   logic [TASK_W-1:0]   link_wr_addr;
   link_entry_type      link_wr_data;
   logic                link_rd_en;
   logic [TASK_W-1:0]   link_rd_addr;

   lock_entry_type      lock_rd;
   logic                lock_wr_en;
   lock_entry_type      lock_wr_data;
   lock_entry_type      upd;
   logic                fin;
   logic                accept;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          rsp_status_ff, rsp_status_in;
   logic                rsp_wv_ff, rsp_wv_in;
   logic [TASK_W-1:0]   rsp_wt_ff, rsp_wt_in;
   logic                rsp_ww_ff, rsp_ww_in;
   logic                rsp_last_ff, rsp_last_in;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // Lock table, read when a request is taken.
   rwl_lock_tbl u_lock_tbl (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (req_lock_index),
      .rd_data (lock_rd),
      .wr_en   (lock_wr_en),
      .wr_addr (lk_ff),
      .wr_data (lock_wr_data)
   );

   // Link table: entry of a queued task names the waiter behind it.
   always_ff @(posedge clock) begin
      if (link_wr_en) begin
         link_mem[link_wr_addr] <= link_wr_data;
      end
      if (link_rd_en) begin
         link_rd_ff <= link_mem[link_rd_addr];
      end
   end

   // Sequencer: lookup and update, then one wake step per cycle on release.
   always_comb begin
      state_in      = state_ff;
      wk_in         = wk_ff;
      wake_cnt_in   = wake_cnt_ff;
      waiting_in    = waiting_ff;
      wl_wr_en      = 1'b0;
      link_wr_en    = 1'b0;
      link_wr_addr  = tid_ff;
      link_wr_data  = '{id: tid_ff, ww: 1'b0};
      link_rd_en    = 1'b0;
      link_rd_addr  = link_rd_ff.id;
      lock_wr_en    = 1'b0;
      upd           = lock_rd;
      fin           = 1'b0;
      rsp_valid_in  = 1'b0;
      rsp_status_in = ST_REFUSED;
      rsp_wv_in     = 1'b0;
      rsp_wt_in     = '0;
      rsp_ww_in     = 1'b0;
      rsp_last_in   = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_LOOKUP;
            end
         end

         S_LOOKUP: begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = 1'b1;
            state_in     = S_IDLE;
            case (act_ff)
               ACT_REINIT: begin
                  // Drop every task queued on this lock.
                  for (int i = 0; i < NUM_TASKS; i++) begin
                     if (wait_lock_ff[i] == lk_ff) begin
                        waiting_in[i] = 1'b0;
                     end
                  end
                  upd           = LOCK_RESET;
                  lock_wr_en    = 1'b1;
                  rsp_status_in = ST_NOW_FREE;
               end

               ACT_READ, ACT_WRITE: begin
                  lock_wr_en = 1'b1;
                  if (waiting_ff[tid_ff]) begin
                     rsp_status_in = ST_REFUSED;
                  end else if (act_ff == ACT_READ &&
                               (lock_rd.mode == MODE_FREE || lock_rd.mode == MODE_READ)) begin
                     if (lock_rd.count >= CNT_MAX) begin
                        rsp_status_in = ST_REFUSED;
                     end else begin
                        upd.count     = lock_rd.count + CNT_W'(1);
                        upd.mode      = MODE_READ;
                        rsp_status_in = ST_GRANTED;
                     end
                  end else if (act_ff == ACT_WRITE && lock_rd.mode == MODE_FREE) begin
                     if (lock_rd.count != '0) begin
                        rsp_status_in = ST_REFUSED;
                     end else begin
                        upd.count     = CNT_W'(1);
                        upd.mode      = MODE_WRITE;
                        rsp_status_in = ST_GRANTED;
                     end
                  end else begin
                     // Append the task to the tail of the wait queue.
                     waiting_in[tid_ff] = 1'b1;
                     wl_wr_en           = 1'b1;
                     if (lock_rd.tail[QIDX_W-1]) begin
                        upd.head    = {1'b0, tid_ff};
                        upd.head_ww = act_ff[0];
                     end else begin
                        link_wr_en   = 1'b1;
                        link_wr_addr = lock_rd.tail[TASK_W-1:0];
                        link_wr_data = '{id: tid_ff, ww: act_ff[0]};
                     end
                     upd.tail = {1'b0, tid_ff};
                     if (act_ff == ACT_WRITE) begin
                        upd.mode = MODE_PEND;
                     end
                     rsp_status_in = ST_QUEUED;
                  end
               end

               default: begin
                  // Release.
                  if (lock_rd.count == '0) begin
                     rsp_status_in = ST_BAD_REL;
                  end else if (lock_rd.count != CNT_W'(1)) begin
                     upd.count     = lock_rd.count - CNT_W'(1);
                     lock_wr_en    = 1'b1;
                     rsp_status_in = ST_STILL_HELD;
                  end else begin
                     upd.count = '0;
                     upd.mode  = MODE_FREE;
                     if (lock_rd.head[QIDX_W-1]) begin
                        lock_wr_en    = 1'b1;
                        rsp_status_in = ST_NOW_FREE;
                     end else begin
                        // Last hold gone with waiters: start the wake walk.
                        rsp_valid_in = 1'b0;
                        rsp_last_in  = 1'b0;
                        wk_in        = upd;
                        wake_cnt_in  = '0;
                        link_rd_en   = 1'b1;
                        link_rd_addr = lock_rd.head[TASK_W-1:0];
                        state_in     = S_WAKE;
                     end
                  end
               end
            endcase
         end

         S_WAKE: begin
            // Wake the head waiter; look one waiter ahead to find the end.
            upd           = wk_ff;
            upd.count     = wk_ff.count + CNT_W'(1);
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_HANDED;
            rsp_wv_in     = 1'b1;
            rsp_wt_in     = wk_ff.head[TASK_W-1:0];
            rsp_ww_in     = wk_ff.head_ww;
            waiting_in[wk_ff.head[TASK_W-1:0]] = 1'b0;
            upd.mode = wk_ff.head_ww ? MODE_WRITE : MODE_READ;
            fin      = wk_ff.head_ww;
            if (wk_ff.head == wk_ff.tail) begin
               upd.head    = EMPTY_Q;
               upd.tail    = EMPTY_Q;
               upd.head_ww = 1'b0;
               fin         = 1'b1;
            end else begin
               upd.head    = {1'b0, link_rd_ff.id};
               upd.head_ww = link_rd_ff.ww;
               if (!wk_ff.head_ww) begin
                  if (wake_cnt_ff == WAKE_W'(MAX_WAKE - 1)) begin
                     fin = 1'b1;
                  end else if (link_rd_ff.ww) begin
                     upd.mode = MODE_PEND;
                     fin      = 1'b1;
                  end
               end
            end
            if (fin) begin
               rsp_last_in = 1'b1;
               lock_wr_en  = 1'b1;
               state_in    = S_IDLE;
            end else begin
               wk_in       = upd;
               wake_cnt_in = wake_cnt_ff + WAKE_W'(1);
               link_rd_en  = 1'b1;
               link_rd_addr = link_rd_ff.id;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign lock_wr_data = upd;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         waiting_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         waiting_ff   <= waiting_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request capture, walk registers and response payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff <= req_action;
         lk_ff  <= req_lock_index;
         tid_ff <= req_task_id;
      end
      if (wl_wr_en) begin
         wait_lock_ff[tid_ff] <= lk_ff;
      end
      wk_ff         <= wk_in;
      wake_cnt_ff   <= wake_cnt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_wv_ff     <= rsp_wv_in;
      rsp_wt_ff     <= rsp_wt_in;
      rsp_ww_ff     <= rsp_ww_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_woken_valid     = rsp_wv_ff;
   assign rsp_woken_task      = rsp_wt_ff;
   assign rsp_woken_for_write = rsp_ww_ff;
   assign rsp_last            = rsp_last_ff;

endmodule

@@ rtl/rwl_checker.sv @@
// ----------------------------------------------------------------------------
// rwl_checker
// Port-level checks of the lock bank: request acceptance and the shape of
// the response stream of one request.
// ----------------------------------------------------------------------------
module rwl_checker
   import rwl_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input logic [2:0]        rsp_status,
   input logic              rsp_woken_valid,
   input logic [TASK_W-1:0] rsp_woken_task,
   input logic              rsp_woken_for_write,
   input logic              rsp_last
);

   // A taken request keeps the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("block not busy after a request was taken");

   // The responses of one request come in back-to-back cycles.
   a_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid)
      else $error("gap inside a response burst");

   // A woken task is only reported as a hand-over.
   a_woken_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_woken_valid |-> rsp_status == ST_HANDED)
      else $error("woken task with a status other than handed over");

   // Without a woken task the task fields read zero.
   a_woken_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_woken_valid |-> rsp_woken_task == '0 && !rsp_woken_for_write)
      else $error("woken task fields set without a woken task");

   // A writer that is woken ends the wake burst.
   a_writer_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_woken_valid && rsp_woken_for_write |-> rsp_last)
      else $error("wake burst continues after a writer");

endmodule

bind rw_lock_with_fifo_waiters_top rwl_checker u_rwl_checker (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .rsp_valid           (rsp_valid),
   .rsp_status          (rsp_status),
   .rsp_woken_valid     (rsp_woken_valid),
   .rsp_woken_task      (rsp_woken_task),
   .rsp_woken_for_write (rsp_woken_for_write),
   .rsp_last            (rsp_last)
);

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the readers-writer lock bank. A scoreboard predicts
// every response from the requests the block accepts and checks the responses
// in order. Stimulus is a directed walk through the lock behavior, then random
// contention, flood and wake scenarios with random gaps between requests.
// ----------------------------------------------------------------------------
module testbench;
   import rwl_pkg::*;

   // One response of the block, in port order.
   typedef struct packed {
      logic [2:0]        status;
      logic              woken_valid;
      logic [TASK_W-1:0] woken_task;
      logic              woken_for_write;
      logic              last;
   } lock_response_type;

   // Predicts the responses of the lock bank and checks the observed ones.
   class lock_bank_scoreboard;
      logic [1:0]        lock_mode   [NUM_LOCKS];
      logic [CNT_W-1:0]  hold_count  [NUM_LOCKS];
      logic [QIDX_W-1:0] wait_head   [NUM_LOCKS];
      logic [QIDX_W-1:0] wait_tail   [NUM_LOCKS];
      logic [QIDX_W-1:0] next_waiter [NUM_TASKS];
      logic              wants_write [NUM_TASKS];
      logic              is_waiting  [NUM_TASKS];
      lock_response_type expected_q[$];
      int                error_count;

      function new();
         error_count = 0;
         for (int i = 0; i < NUM_LOCKS; i++) begin
            lock_mode[i]  = MODE_FREE;
            hold_count[i] = '0;
            wait_head[i]  = EMPTY_Q;
            wait_tail[i]  = EMPTY_Q;
         end
         for (int t = 0; t < NUM_TASKS; t++) begin
            next_waiter[t] = '0;
            wants_write[t] = 1'b0;
            is_waiting[t]  = 1'b0;
         end
      endfunction

      function lock_response_type make_response(logic [2:0] st, logic wv,
                                                logic [TASK_W-1:0] wt, logic ww);
         lock_response_type rsp;
         rsp.status          = st;
         rsp.woken_valid     = wv;
         rsp.woken_task      = wt;
         rsp.woken_for_write = ww;
         rsp.last            = 1'b0;
         return rsp;
      endfunction

      // Append a task to the tail of a lock's wait queue.
      function void add_waiter(int lk, logic [TASK_W-1:0] tk, logic wr);
         wants_write[tk] = wr;
         is_waiting[tk]  = 1'b1;
         next_waiter[tk] = EMPTY_Q;
         if (wait_tail[lk] == EMPTY_Q) begin
            wait_head[lk] = QIDX_W'(tk);
         end else begin
            next_waiter[wait_tail[lk][TASK_W-1:0]] = QIDX_W'(tk);
         end
         wait_tail[lk] = QIDX_W'(tk);
      endfunction

      // Drop every waiter of a lock and return it to free.
      function void clear_lock(int lk);
         logic [QIDX_W-1:0] walk;
         logic              done;
         int                n;
         walk = wait_head[lk];
         done = 1'b0;
         n    = 0;
         while (!done && n < NUM_TASKS && walk != EMPTY_Q) begin
            is_waiting[walk[TASK_W-1:0]] = 1'b0;
            if (walk == wait_tail[lk]) begin
               done = 1'b1;
            end else begin
               walk = next_waiter[walk[TASK_W-1:0]];
            end
            n++;
         end
         lock_mode[lk]  = MODE_FREE;
         hold_count[lk] = '0;
         wait_head[lk]  = EMPTY_Q;
         wait_tail[lk]  = EMPTY_Q;
      endfunction

      // Work out the responses of one accepted request and queue them.
      function void log_request(logic [1:0] act, logic [LOCK_W-1:0] lk_in,
                                logic [TASK_W-1:0] tk);
         lock_response_type batch[$];
         int                lk;
         logic [TASK_W-1:0] hd;
         logic              wr;
         logic              stop;
         lk = int'(lk_in);
         if (act == ACT_REINIT) begin
            clear_lock(lk);
            batch.push_back(make_response(ST_NOW_FREE, 1'b0, '0, 1'b0));
         end else if (act == ACT_READ || act == ACT_WRITE) begin
            if (is_waiting[tk]) begin
               batch.push_back(make_response(ST_REFUSED, 1'b0, '0, 1'b0));
            end else if (act == ACT_READ) begin
               if (lock_mode[lk] == MODE_FREE || lock_mode[lk] == MODE_READ) begin
                  if (hold_count[lk] == CNT_MAX) begin
                     batch.push_back(make_response(ST_REFUSED, 1'b0, '0, 1'b0));
                  end else begin
                     hold_count[lk]++;
                     lock_mode[lk] = MODE_READ;
                     batch.push_back(make_response(ST_GRANTED, 1'b0, '0, 1'b0));
                  end
               end else begin
                  add_waiter(lk, tk, 1'b0);
                  batch.push_back(make_response(ST_QUEUED, 1'b0, '0, 1'b0));
               end
            end else begin
               if (lock_mode[lk] == MODE_FREE) begin
                  if (hold_count[lk] != '0) begin
                     batch.push_back(make_response(ST_REFUSED, 1'b0, '0, 1'b0));
                  end else begin
                     hold_count[lk] = CNT_W'(1);
                     lock_mode[lk]  = MODE_WRITE;
                     batch.push_back(make_response(ST_GRANTED, 1'b0, '0, 1'b0));
                  end
               end else begin
                  add_waiter(lk, tk, 1'b1);
                  lock_mode[lk] = MODE_PEND;
                  batch.push_back(make_response(ST_QUEUED, 1'b0, '0, 1'b0));
               end
            end
         end else begin
            // Release: the last hold wakes waiters from the head of the queue.
            if (hold_count[lk] == '0) begin
               batch.push_back(make_response(ST_BAD_REL, 1'b0, '0, 1'b0));
            end else begin
               hold_count[lk]--;
               if (hold_count[lk] != '0) begin
                  batch.push_back(make_response(ST_STILL_HELD, 1'b0, '0, 1'b0));
               end else begin
                  lock_mode[lk] = MODE_FREE;
                  stop = 1'b0;
                  while (!stop && batch.size() < MAX_WAKE && wait_head[lk] != EMPTY_Q) begin
                     hd = wait_head[lk][TASK_W-1:0];
                     wr = wants_write[hd];
                     if (wr && lock_mode[lk] == MODE_READ) begin
                        // A writer ends a run of woken readers.
                        lock_mode[lk] = MODE_PEND;
                        stop = 1'b1;
                     end else begin
                        if (wait_head[lk] == wait_tail[lk]) begin
                           wait_head[lk] = EMPTY_Q;
                           wait_tail[lk] = EMPTY_Q;
                        end else begin
                           wait_head[lk] = next_waiter[hd];
                        end
                        is_waiting[hd] = 1'b0;
                        hold_count[lk]++;
                        batch.push_back(make_response(ST_HANDED, 1'b1, hd, wr));
                        if (wr) begin
                           lock_mode[lk] = MODE_WRITE;
                           stop = 1'b1;
                        end else begin
                           lock_mode[lk] = MODE_READ;
                        end
                     end
                  end
                  if (batch.size() == 0) begin
                     batch.push_back(make_response(ST_NOW_FREE, 1'b0, '0, 1'b0));
                  end
               end
            end
         end
         batch[batch.size()-1].last = 1'b1;
         foreach (batch[i]) expected_q.push_back(batch[i]);
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            error_count++;
         end
      endfunction

      // Check one observed response against the oldest prediction.
      function void check_response(lock_response_type got);
         lock_response_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected response: expected none, actual status=%0d task=%0d",
                     $time, got.status, got.woken_task);
            error_count++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("status", int'(want.status), int'(got.status));
         compare_field("woken_valid", int'(want.woken_valid), int'(got.woken_valid));
         compare_field("woken_task", int'(want.woken_task), int'(got.woken_task));
         compare_field("woken_for_write", int'(want.woken_for_write),
                       int'(got.woken_for_write));
         compare_field("last", int'(want.last), int'(got.last));
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [1:0]        req_action;
   logic [LOCK_W-1:0] req_lock_index;
   logic [TASK_W-1:0] req_task_id;
   logic              rsp_valid;
   logic [2:0]        rsp_status;
   logic              rsp_woken_valid;
   logic [TASK_W-1:0] rsp_woken_task;
   logic              rsp_woken_for_write;
   logic              rsp_last;

   lock_bank_scoreboard sb;
   int                  sent_count;
   bit                  no_idle;

   rw_lock_with_fifo_waiters_top u_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_action          (req_action),
      .req_lock_index      (req_lock_index),
      .req_task_id         (req_task_id),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_woken_valid     (rsp_woken_valid),
      .rsp_woken_task      (rsp_woken_task),
      .rsp_woken_for_write (rsp_woken_for_write),
      .rsp_last            (rsp_last)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Safety limit for a hung run.
   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

   // Watch both channels at the rising edge: check responses, log requests.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            sb.check_response({rsp_status, rsp_woken_valid, rsp_woken_task,
                               rsp_woken_for_write, rsp_last});
         end
         if (start && !busy) begin
            sb.log_request(req_action, req_lock_index, req_task_id);
         end
      end
   end

   // Present one request after a random gap and hold it until it is taken.
   task automatic send_request(input logic [1:0] act, input int lk, input int tk);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start          = 1'b1;
      req_action     = act;
      req_lock_index = LOCK_W'(lk);
      req_task_id    = TASK_W'(tk);
      do @(posedge clock); while (busy);
      @(negedge clock);
      sent_count++;
   endtask

   // A lock is taken, a few tasks queue behind it, then releases drain it.
   task automatic run_contention();
      int lk;
      int depth;
      lk    = $urandom_range(0, NUM_LOCKS-1);
      depth = $urandom_range(1, 6);
      send_request($urandom_range(0, 1) ? ACT_WRITE : ACT_READ, lk,
                   $urandom_range(0, NUM_TASKS-1));
      repeat (depth) begin
         send_request($urandom_range(0, 1) ? ACT_WRITE : ACT_READ, lk,
                      $urandom_range(0, NUM_TASKS-1));
      end
      repeat (depth + $urandom_range(1, 3)) begin
         send_request(ACT_RELEASE, lk, $urandom_range(0, NUM_TASKS-1));
      end
   endtask

   // Every task queues as a reader behind a writer, so one release wakes all.
   task automatic run_full_wake();
      int order[NUM_TASKS];
      int lk;
      int j;
      int swap;
      lk = $urandom_range(0, NUM_LOCKS-1);
      for (int i = 0; i < NUM_LOCKS; i++) send_request(ACT_REINIT, i, $urandom_range(0, 15));
      for (int i = 0; i < NUM_TASKS; i++) order[i] = i;
      for (int i = NUM_TASKS-1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         swap     = order[i];
         order[i] = order[j];
         order[j] = swap;
      end
      send_request(ACT_WRITE, lk, order[0]);
      for (int i = 0; i < NUM_TASKS; i++) send_request(ACT_READ, lk, order[i]);
      send_request(ACT_RELEASE, lk, 0);
   endtask

   // Enough readers to saturate the hold counter of one lock.
   task automatic run_reader_flood();
      int lk;
      lk = $urandom_range(0, NUM_LOCKS-1);
      send_request(ACT_REINIT, lk, 0);
      repeat (34) send_request(ACT_READ, lk, $urandom_range(0, NUM_TASKS-1));
      repeat (2) send_request(ACT_RELEASE, lk, 0);
   endtask

   // Main sequence.
   initial begin
      int  target;
      int  pick;
      bit  wake_done;
      bit  flood_done;
      sb             = new();
      reset          = 1'b1;
      start          = 1'b0;
      req_action     = ACT_READ;
      req_lock_index = '0;
      req_task_id    = '0;
      sent_count     = 0;
      no_idle        = 1'b0;
      wake_done      = 1'b0;
      flood_done     = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: readers, a pending writer blocking later readers, refusal
      // of a task already waiting, a wake run that stops before a writer,
      // release with no holders, and reinitialize with tasks queued.
      send_request(ACT_RELEASE, 7, 0);
      send_request(ACT_READ, 7, 15);
      send_request(ACT_READ, 7, 0);
      send_request(ACT_WRITE, 7, 3);
      send_request(ACT_READ, 7, 4);
      send_request(ACT_WRITE, 7, 3);
      send_request(ACT_READ, 7, 5);
      send_request(ACT_WRITE, 7, 6);
      send_request(ACT_RELEASE, 7, 0);
      send_request(ACT_RELEASE, 7, 0);
      send_request(ACT_RELEASE, 7, 0);
      send_request(ACT_RELEASE, 7, 0);
      send_request(ACT_RELEASE, 7, 0);
      send_request(ACT_RELEASE, 7, 0);
      send_request(ACT_WRITE, 0, 0);
      send_request(ACT_READ, 0, 1);
      send_request(ACT_WRITE, 0, 2);
      send_request(ACT_READ, 0, 15);
      send_request(ACT_REINIT, 0, 15);
      send_request(ACT_READ, 0, 1);
      send_request(ACT_WRITE, 0, 2);
      send_request(ACT_RELEASE, 0, 0);
      send_request(ACT_RELEASE, 0, 0);
      send_request(ACT_REINIT, 3, 0);

      // Random scenarios, each with its own idling style.
      target = sent_count + 136;
      while (sent_count < target) begin
         no_idle = ($urandom_range(0, 3) == 0);
         pick    = $urandom_range(0, 9);
         if (!wake_done && sent_count >= target - 120) begin
            run_full_wake();
            wake_done = 1'b1;
         end else if (!flood_done && sent_count >= target - 70) begin
            run_reader_flood();
            flood_done = 1'b1;
         end else if (pick < 6) begin
            run_contention();
         end else begin
            repeat ($urandom_range(1, 3)) begin
               send_request(2'($urandom_range(0, 3)), $urandom_range(0, NUM_LOCKS-1),
                            $urandom_range(0, NUM_TASKS-1));
            end
         end
      end
      start = 1'b0;

      // Drain, then allow for a late or extra response.
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.error_count == 0 && sb.expected_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
